// ===== rtl/itp_pkg.sv =====
// shared types, constants and token helpers for the infix to postfix converter
package itp_pkg;

    // sizing
    localparam int STACK_DEPTH = 32;
    localparam int MAX_TOKENS  = 128;
    localparam int QUEUE_DEPTH = 4;

    localparam int KIND_W   = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(MAX_TOKENS + 1);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    // token kinds
    localparam logic [KIND_W-1:0] K_NUM   = 5'd0;
    localparam logic [KIND_W-1:0] K_ADD   = 5'd1;
    localparam logic [KIND_W-1:0] K_SUB   = 5'd2;
    localparam logic [KIND_W-1:0] K_MUL   = 5'd3;
    localparam logic [KIND_W-1:0] K_DIV   = 5'd4;
    localparam logic [KIND_W-1:0] K_POW   = 5'd5;
    localparam logic [KIND_W-1:0] K_NEG   = 5'd6;
    localparam logic [KIND_W-1:0] K_LP    = 5'd7;
    localparam logic [KIND_W-1:0] K_RP    = 5'd8;
    localparam logic [KIND_W-1:0] K_FN_LO = 5'd9;
    localparam logic [KIND_W-1:0] K_FN_HI = 5'd19;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVF = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SYN = 2'd2;

    // token class as seen by the back end
    typedef enum logic [2:0] {
        CLS_NUM,
        CLS_OP,
        CLS_PUSH,
        CLS_RP,
        CLS_OTHER
    } tok_cls_t;

    // one queued infix token
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               imul;
        tok_cls_t           cls;
    } q_entry_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_OPLOOP,
        S_RPLOOP,
        S_RPFUNC,
        S_FLUSH,
        S_FINISH
    } back_state_t;

    function automatic logic is_fn(input logic [KIND_W-1:0] k);
        return k inside {[K_FN_LO:K_FN_HI]};
    endfunction

    function automatic logic is_op(input logic [KIND_W-1:0] k);
        return k inside {[K_ADD:K_NEG]};
    endfunction

    function automatic logic [2:0] prec(input logic [KIND_W-1:0] k);
        logic [2:0] p;
        case (k)
            K_ADD, K_SUB: p = 3'd1;
            K_MUL, K_DIV: p = 3'd2;
            K_NEG:        p = 3'd3;
            K_POW:        p = 3'd4;
            default:      p = 3'd0;
        endcase
        return p;
    endfunction

    function automatic logic right_assoc(input logic [KIND_W-1:0] k);
        return (k == K_POW) || (k == K_NEG);
    endfunction

    function automatic tok_cls_t classify(input logic [KIND_W-1:0] k);
        tok_cls_t c;
        if (k == K_NUM) begin
            c = CLS_NUM;
        end else if ((k == K_LP) || (k == K_NEG) || is_fn(k)) begin
            c = CLS_PUSH;
        end else if (is_op(k)) begin
            c = CLS_OP;
        end else if (k == K_RP) begin
            c = CLS_RP;
        end else begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage

// ===== rtl/itp_front.sv =====
// front end: accepts infix beats, classifies them and flags implicit multiplies
module itp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [itp_pkg::KIND_W-1:0]    s_tok_kind,
    input  logic [itp_pkg::VALUE_W-1:0]   s_tok_value,
    input  logic                          s_tok_last,
    output logic                          push_valid,
    input  logic                          push_ready,
    output itp_pkg::q_entry_t             push_entry
);

    logic prev_val_reg;
    logic prev_val_next;
    logic accept;
    logic cur_factor;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    // a number, left parenthesis or function right after a value gets a multiply
    assign cur_factor = (s_tok_kind == itp_pkg::K_NUM) || (s_tok_kind == itp_pkg::K_LP) ||
                        itp_pkg::is_fn(s_tok_kind);

    always_comb begin
        push_entry.kind  = s_tok_kind;
        push_entry.value = s_tok_value;
        push_entry.last  = s_tok_last;
        push_entry.imul  = prev_val_reg && cur_factor;
        push_entry.cls   = itp_pkg::classify(s_tok_kind);
    end

    // previous token state, cleared at the end of each expression
    always_comb begin
        prev_val_next = prev_val_reg;
        if (accept) begin
            prev_val_next = !s_tok_last &&
                            ((s_tok_kind == itp_pkg::K_NUM) || (s_tok_kind == itp_pkg::K_RP));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_val_reg <= 1'b0;
        end else begin
            prev_val_reg <= prev_val_next;
        end
    end

endmodule

// ===== rtl/itp_queue.sv =====
// small token queue between the front and back ends
module itp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  itp_pkg::q_entry_t  wr_entry,
    output logic               rd_valid,
    input  logic               rd_pop,
    output itp_pkg::q_entry_t  rd_entry
);

    itp_pkg::q_entry_t                 store_reg [itp_pkg::QUEUE_DEPTH];
    logic [itp_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [itp_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [itp_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign wr_ready = count_reg != itp_pkg::QCNT_W'(itp_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_entry = store_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == itp_pkg::QPTR_W'(itp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == itp_pkg::QPTR_W'(itp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            store_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== rtl/itp_back.sv =====
// back end: operator stack sequencer, one push or pop per cycle unless stalled, result buffering
module itp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  itp_pkg::q_entry_t             q_entry,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [itp_pkg::KIND_W-1:0]    m_out_kind,
    output logic [itp_pkg::VALUE_W-1:0]   m_out_value,
    output logic [itp_pkg::STATUS_W-1:0]  m_out_status,
    output logic                          m_out_last
);

    typedef struct packed {
        logic                          fetch;
        logic                          emit;
        logic [itp_pkg::KIND_W-1:0]    em_kind;
        logic                          em_num;
        logic [itp_pkg::STATUS_W-1:0]  em_status;
        logic                          push;
        logic                          pop;
        logic                          inc_infix;
        logic                          imul_done;
        logic                          set_err;
        logic                          release_out;
        logic                          end_expr;
        logic                          set_drop;
    } back_ctl_t;

    itp_pkg::back_state_t                state_reg, state_next;
    back_ctl_t                           act;
    back_ctl_t                           ctl;
    logic                                stall;

    // current token
    logic [itp_pkg::KIND_W-1:0]          tok_kind_reg, tok_kind_next;
    logic [itp_pkg::VALUE_W-1:0]         tok_value_reg, tok_value_next;
    logic                                tok_last_reg, tok_last_next;
    itp_pkg::tok_cls_t                   tok_cls_reg, tok_cls_next;
    logic                                imul_reg, imul_next;
    logic                                err_reg, err_next;

    // expression state
    logic [itp_pkg::KIND_W-1:0]          stack_reg [itp_pkg::STACK_DEPTH];
    logic [itp_pkg::DEPTH_W-1:0]         depth_reg, depth_next;
    logic [itp_pkg::CNT_W-1:0]           infix_cnt_reg, infix_cnt_next;
    logic [itp_pkg::CNT_W-1:0]           postfix_cnt_reg, postfix_cnt_next;
    logic                                drop_reg, drop_next;

    // one result held back until its last flag is known
    logic                                hold_valid_reg, hold_valid_next;
    logic [itp_pkg::KIND_W-1:0]          hold_kind_reg, hold_kind_next;
    logic [itp_pkg::VALUE_W-1:0]         hold_value_reg, hold_value_next;
    logic [itp_pkg::STATUS_W-1:0]        hold_status_reg, hold_status_next;

    // output register
    logic                                out_valid_reg, out_valid_next;
    logic [itp_pkg::KIND_W-1:0]          out_kind_reg, out_kind_next;
    logic [itp_pkg::VALUE_W-1:0]         out_value_reg, out_value_next;
    logic [itp_pkg::STATUS_W-1:0]        out_status_reg, out_status_next;
    logic                                out_last_reg, out_last_next;

    logic [itp_pkg::KIND_W-1:0]          cur_kind;
    itp_pkg::tok_cls_t                   cur_cls;
    logic [itp_pkg::DEPTH_W-1:0]         depth_dec;
    logic [itp_pkg::KIND_W-1:0]          top;
    logic                                stack_empty;
    logic                                stack_full;
    logic                                infix_full;
    logic                                postfix_full;
    logic                                pop_go;
    logic                                out_free;
    logic                                can_emit;
    logic                                out_load;
    itp_pkg::back_state_t                after_state;

    assign m_valid      = out_valid_reg;
    assign m_out_kind   = out_kind_reg;
    assign m_out_value  = out_value_reg;
    assign m_out_status = out_status_reg;
    assign m_out_last   = out_last_reg;
    assign q_pop        = ctl.fetch;

    // the pending implicit multiply is handled before the token itself
    assign cur_kind = imul_reg ? itp_pkg::K_MUL : tok_kind_reg;
    assign cur_cls  = imul_reg ? itp_pkg::CLS_OP : tok_cls_reg;

    // top of stack and limits
    assign depth_dec    = depth_reg - 1'b1;
    assign top          = stack_reg[depth_dec[itp_pkg::IDX_W-1:0]];
    assign stack_empty  = depth_reg == '0;
    assign stack_full   = depth_reg >= itp_pkg::DEPTH_W'(itp_pkg::STACK_DEPTH);
    assign infix_full   = infix_cnt_reg >= itp_pkg::CNT_W'(itp_pkg::MAX_TOKENS);
    assign postfix_full = postfix_cnt_reg >= itp_pkg::CNT_W'(itp_pkg::MAX_TOKENS);

    // function on top, or operator of higher precedence (equal for left assoc incoming), pops first
    assign pop_go = itp_pkg::is_fn(top) ||
                    (itp_pkg::is_op(top) &&
                     ((itp_pkg::prec(top) > itp_pkg::prec(cur_kind)) ||
                      ((itp_pkg::prec(top) == itp_pkg::prec(cur_kind)) &&
                       !itp_pkg::right_assoc(cur_kind))));

    assign out_free    = !out_valid_reg || m_ready;
    assign can_emit    = !hold_valid_reg || out_free;
    assign after_state = imul_reg ? itp_pkg::S_START :
                         (tok_last_reg ? itp_pkg::S_FLUSH : itp_pkg::S_FINISH);

    // sequencer actions per state
    always_comb begin
        act = '0;
        case (state_reg)
            itp_pkg::S_IDLE: begin
                if (q_valid) begin
                    act.fetch    = 1'b1;
                    act.end_expr = drop_reg && q_entry.last;
                end
            end
            itp_pkg::S_START: begin
                if (infix_full) begin
                    act.emit      = 1'b1;
                    act.em_status = itp_pkg::ST_OVF;
                    act.set_err   = 1'b1;
                end else begin
                    act.inc_infix = 1'b1;
                    case (cur_cls)
                        itp_pkg::CLS_NUM: begin
                            act.emit = 1'b1;
                            if (postfix_full) begin
                                act.em_status = itp_pkg::ST_OVF;
                                act.set_err   = 1'b1;
                            end else begin
                                act.em_kind   = itp_pkg::K_NUM;
                                act.em_num    = 1'b1;
                                act.imul_done = imul_reg;
                            end
                        end
                        itp_pkg::CLS_PUSH: begin
                            if (stack_full) begin
                                act.emit      = 1'b1;
                                act.em_status = itp_pkg::ST_OVF;
                                act.set_err   = 1'b1;
                            end else begin
                                act.push      = 1'b1;
                                act.imul_done = imul_reg;
                            end
                        end
                        itp_pkg::CLS_OP, itp_pkg::CLS_RP: begin
                            // work continues in the loop states
                        end
                        default: begin
                            act.imul_done = imul_reg;
                        end
                    endcase
                end
            end
            itp_pkg::S_OPLOOP: begin
                if (!stack_empty && pop_go) begin
                    act.emit = 1'b1;
                    if (postfix_full) begin
                        act.em_status = itp_pkg::ST_OVF;
                        act.set_err   = 1'b1;
                    end else begin
                        act.em_kind = top;
                        act.pop     = 1'b1;
                    end
                end else if (stack_full) begin
                    act.emit      = 1'b1;
                    act.em_status = itp_pkg::ST_OVF;
                    act.set_err   = 1'b1;
                end else begin
                    act.push      = 1'b1;
                    act.imul_done = imul_reg;
                end
            end
            itp_pkg::S_RPLOOP: begin
                if (stack_empty) begin
                    act.emit      = 1'b1;
                    act.em_status = itp_pkg::ST_SYN;
                    act.set_err   = 1'b1;
                end else if (top != itp_pkg::K_LP) begin
                    act.emit = 1'b1;
                    if (postfix_full) begin
                        act.em_status = itp_pkg::ST_OVF;
                        act.set_err   = 1'b1;
                    end else begin
                        act.em_kind = top;
                        act.pop     = 1'b1;
                    end
                end else begin
                    // drop the matching left parenthesis
                    act.pop = 1'b1;
                end
            end
            itp_pkg::S_RPFUNC: begin
                if (!stack_empty && itp_pkg::is_fn(top)) begin
                    act.emit = 1'b1;
                    if (postfix_full) begin
                        act.em_status = itp_pkg::ST_OVF;
                        act.set_err   = 1'b1;
                    end else begin
                        act.em_kind   = top;
                        act.pop       = 1'b1;
                        act.imul_done = imul_reg;
                    end
                end else begin
                    act.imul_done = imul_reg;
                end
            end
            itp_pkg::S_FLUSH: begin
                if (stack_empty) begin
                    act.imul_done = 1'b0;
                end else if (top == itp_pkg::K_LP) begin
                    act.emit      = 1'b1;
                    act.em_status = itp_pkg::ST_SYN;
                    act.set_err   = 1'b1;
                end else begin
                    act.emit = 1'b1;
                    if (postfix_full) begin
                        act.em_status = itp_pkg::ST_OVF;
                        act.set_err   = 1'b1;
                    end else begin
                        act.em_kind = top;
                        act.pop     = 1'b1;
                    end
                end
            end
            itp_pkg::S_FINISH: begin
                act.release_out = 1'b1;
                act.end_expr    = tok_last_reg;
                act.set_drop    = !tok_last_reg && err_reg;
            end
            default: begin
                act = '0;
            end
        endcase
    end

    // wait for room on the output side, everything held back whole
    assign stall = (act.emit && !can_emit) ||
                   (act.release_out && (hold_valid_reg || tok_last_reg) && !out_free);
    assign ctl   = stall ? '0 : act;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        if (!stall) begin
            case (state_reg)
                itp_pkg::S_IDLE: begin
                    if (q_valid && !drop_reg) begin
                        state_next = itp_pkg::S_START;
                    end
                end
                itp_pkg::S_START: begin
                    if (act.set_err) begin
                        state_next = itp_pkg::S_FINISH;
                    end else if (cur_cls == itp_pkg::CLS_OP) begin
                        state_next = itp_pkg::S_OPLOOP;
                    end else if (cur_cls == itp_pkg::CLS_RP) begin
                        state_next = itp_pkg::S_RPLOOP;
                    end else begin
                        state_next = after_state;
                    end
                end
                itp_pkg::S_OPLOOP: begin
                    if (act.set_err) begin
                        state_next = itp_pkg::S_FINISH;
                    end else if (act.push) begin
                        state_next = after_state;
                    end
                end
                itp_pkg::S_RPLOOP: begin
                    if (act.set_err) begin
                        state_next = itp_pkg::S_FINISH;
                    end else if (act.pop && !act.emit) begin
                        state_next = itp_pkg::S_RPFUNC;
                    end
                end
                itp_pkg::S_RPFUNC: begin
                    if (act.set_err) begin
                        state_next = itp_pkg::S_FINISH;
                    end else begin
                        state_next = after_state;
                    end
                end
                itp_pkg::S_FLUSH: begin
                    if (act.set_err || stack_empty) begin
                        state_next = itp_pkg::S_FINISH;
                    end
                end
                itp_pkg::S_FINISH: begin
                    state_next = itp_pkg::S_IDLE;
                end
                default: begin
                    state_next = itp_pkg::S_IDLE;
                end
            endcase
        end
    end

    // token, counters and stack depth
    always_comb begin
        tok_kind_next    = tok_kind_reg;
        tok_value_next   = tok_value_reg;
        tok_last_next    = tok_last_reg;
        tok_cls_next     = tok_cls_reg;
        imul_next        = imul_reg;
        err_next         = err_reg;
        depth_next       = depth_reg;
        infix_cnt_next   = infix_cnt_reg;
        postfix_cnt_next = postfix_cnt_reg;
        drop_next        = drop_reg;
        if (ctl.fetch) begin
            tok_kind_next  = q_entry.kind;
            tok_value_next = q_entry.value;
            tok_last_next  = q_entry.last;
            tok_cls_next   = q_entry.cls;
            imul_next      = q_entry.imul;
            err_next       = 1'b0;
        end
        if (ctl.imul_done) begin
            imul_next = 1'b0;
        end
        if (ctl.set_err) begin
            err_next = 1'b1;
        end
        if (ctl.inc_infix) begin
            infix_cnt_next = infix_cnt_reg + 1'b1;
        end
        if (ctl.emit && (ctl.em_status == itp_pkg::ST_OK)) begin
            postfix_cnt_next = postfix_cnt_reg + 1'b1;
        end
        if (ctl.push) begin
            depth_next = depth_reg + 1'b1;
        end else if (ctl.pop) begin
            depth_next = depth_dec;
        end
        if (ctl.set_drop) begin
            drop_next = 1'b1;
        end
        if (ctl.end_expr) begin
            depth_next       = '0;
            infix_cnt_next   = '0;
            postfix_cnt_next = '0;
            drop_next        = 1'b0;
        end
    end

    // held result and output register
    always_comb begin
        hold_valid_next  = hold_valid_reg;
        hold_kind_next   = hold_kind_reg;
        hold_value_next  = hold_value_reg;
        hold_status_next = hold_status_reg;
        out_load         = (ctl.emit && hold_valid_reg) ||
                           (ctl.release_out && (hold_valid_reg || tok_last_reg));
        out_kind_next    = out_kind_reg;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        if (out_load) begin
            if (hold_valid_reg) begin
                out_kind_next   = hold_kind_reg;
                out_value_next  = hold_value_reg;
                out_status_next = hold_status_reg;
                out_last_next   = ctl.release_out && (tok_last_reg || err_reg);
            end else begin
                // last token released nothing: end marker
                out_kind_next   = itp_pkg::K_RP;
                out_value_next  = '0;
                out_status_next = itp_pkg::ST_OK;
                out_last_next   = 1'b1;
            end
        end
        out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
        if (ctl.emit) begin
            hold_valid_next  = 1'b1;
            hold_kind_next   = ctl.em_kind;
            hold_value_next  = ctl.em_num ? tok_value_reg : '0;
            hold_status_next = ctl.em_status;
        end else if (ctl.release_out) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= itp_pkg::S_IDLE;
            imul_reg        <= 1'b0;
            err_reg         <= 1'b0;
            depth_reg       <= '0;
            infix_cnt_reg   <= '0;
            postfix_cnt_reg <= '0;
            drop_reg        <= 1'b0;
            hold_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            imul_reg        <= imul_next;
            err_reg         <= err_next;
            depth_reg       <= depth_next;
            infix_cnt_reg   <= infix_cnt_next;
            postfix_cnt_reg <= postfix_cnt_next;
            drop_reg        <= drop_next;
            hold_valid_reg  <= hold_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tok_kind_reg    <= tok_kind_next;
        tok_value_reg   <= tok_value_next;
        tok_last_reg    <= tok_last_next;
        tok_cls_reg     <= tok_cls_next;
        hold_kind_reg   <= hold_kind_next;
        hold_value_reg  <= hold_value_next;
        hold_status_reg <= hold_status_next;
        out_kind_reg    <= out_kind_next;
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    // operator stack write port
    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            stack_reg[depth_reg[itp_pkg::IDX_W-1:0]] <= cur_kind;
        end
    end

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// top level of the streaming infix to postfix converter
// Infix tokens enter one beat at a time into a four-entry queue, so the input
// keeps accepting while the stack sequencer works. The sequencer takes a
// number, a left parenthesis, a function, a negate or an unknown kind through
// fetch, start and finish; a binary operator first pops what must leave the
// stack before it and is then pushed; an implicit multiply is handled like
// one ahead of its token; a right parenthesis pops the operators above its
// left parenthesis, drops it and then pops the function of a closed call;
// the final token of an expression flushes the stack. The single operator
// stack does one push or one pop per cycle unless the result side stalls.
// Every result passes through a one-entry hold buffer so its last flag is
// known, then an output register; a stalled result side stops the sequencer
// but not the queue. Tokens dropped after an error are taken from the queue
// one by one and discarded.
module infix_to_postfix_converter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [itp_pkg::KIND_W-1:0]    s_tok_kind,
    input  logic [itp_pkg::VALUE_W-1:0]   s_tok_value,
    input  logic                          s_tok_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [itp_pkg::KIND_W-1:0]    m_out_kind,
    output logic [itp_pkg::VALUE_W-1:0]   m_out_value,
    output logic [itp_pkg::STATUS_W-1:0]  m_out_status,
    output logic                          m_out_last
);

    logic               push_valid;
    logic               push_ready;
    itp_pkg::q_entry_t  push_entry;
    logic               q_valid;
    logic               q_pop;
    itp_pkg::q_entry_t  q_entry;

    // classification and implicit multiply
    itp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_tok_kind (s_tok_kind),
        .s_tok_value(s_tok_value),
        .s_tok_last (s_tok_last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // decoupling queue
    itp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(push_valid),
        .wr_ready(push_ready),
        .wr_entry(push_entry),
        .rd_valid(q_valid),
        .rd_pop  (q_pop),
        .rd_entry(q_entry)
    );

    // stack sequencer and result output
    itp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_kind  (m_out_kind),
        .m_out_value (m_out_value),
        .m_out_status(m_out_status),
        .m_out_last  (m_out_last)
    );

endmodule

// ===== rtl/itp_checker.sv =====
// port level checks for the infix to postfix converter, bound to the top level
module itp_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [itp_pkg::KIND_W-1:0]    s_tok_kind,
    input  logic [itp_pkg::VALUE_W-1:0]   s_tok_value,
    input  logic                          s_tok_last,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [itp_pkg::KIND_W-1:0]    m_out_kind,
    input  logic [itp_pkg::VALUE_W-1:0]   m_out_value,
    input  logic [itp_pkg::STATUS_W-1:0]  m_out_status,
    input  logic                          m_out_last
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_kind) && $stable(m_out_value) &&
                                $stable(m_out_status) && $stable(m_out_last))
        else $error("result beat changed while stalled");

    // an error beat is final and carries no token
    a_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_status != itp_pkg::ST_OK) |->
            m_out_last && (m_out_kind == itp_pkg::K_NUM) && (m_out_value == '0))
        else $error("malformed error beat");

    // only numbers carry a value
    a_val_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_kind != itp_pkg::K_NUM) |-> m_out_value == '0)
        else $error("value on a non-number beat");

    // no left parenthesis ever, right parenthesis only as end marker
    a_paren: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_out_kind == itp_pkg::K_LP) ||
                    ((m_out_kind == itp_pkg::K_RP) &&
                     (!m_out_last || (m_out_status != itp_pkg::ST_OK)))) |-> 1'b0)
        else $error("parenthesis in postfix stream");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);
